// ===== rtl/core/pipid_pkg.sv =====
// ----------------------------------------------------------------------------
// pipid_pkg
// Shared types, constants and fixed-point helpers for the PID controller.
// ----------------------------------------------------------------------------
package pipid_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_GAIN_P      = 3'd1,
    CFG_GAIN_I      = 3'd2,
    CFG_GAIN_D      = 3'd3,
    CFG_INTEG_LIMIT = 3'd4
  } cfg_idx_e;

  localparam logic [63:0] FRAC_MASK = 64'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     mode_incremental;
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic [LIMIT_W-1:0]       integ_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] opnd_p;
    logic signed [DATA_W-1:0] opnd_i;
    logic signed [DATA_W-1:0] opnd_d;
    logic                     flag;
  } opnd_t;

  typedef struct packed {
    logic signed [2*DATA_W-1:0] prod_p;
    logic signed [2*DATA_W-1:0] prod_i;
    logic signed [2*DATA_W-1:0] prod_d;
    logic                       flag;
  } prod_t;

  function automatic logic ovf33(input logic signed [DATA_W:0] v);
    return v[DATA_W] ^ v[DATA_W-1];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? S32_MIN : S32_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Scales a full product down by the fraction width, rounding toward zero.
  function automatic logic signed [2*DATA_W-1:0] qscale(
      input logic signed [2*DATA_W-1:0] p);
    logic signed [2*DATA_W-1:0] q;
    q = p >>> FRAC_BITS;
    if (p[2*DATA_W-1] && (|(p & FRAC_MASK))) begin
      q = q + 64'sd1;
    end
    return q;
  endfunction

  function automatic logic ovf64(input logic signed [2*DATA_W-1:0] q);
    return (q > 64'(S32_MAX)) || (q < 64'(S32_MIN));
  endfunction

  function automatic logic signed [DATA_W-1:0] sat64(input logic signed [2*DATA_W-1:0] q);
    logic signed [DATA_W-1:0] r;
    if (q > 64'(S32_MAX)) begin
      r = S32_MAX;
    end else if (q < 64'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = q[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/positional_incremental_pid_top.sv =====
// ----------------------------------------------------------------------------
// positional_incremental_pid_top
// PID controller in positional or incremental form, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle while out_ready_i does not stall it,
// set by the three-stage pipeline: operand stage, multiplier stage and
// output sum stage.
// Reset clears the registers, the controller state and the pipeline at once.
// ----------------------------------------------------------------------------
module positional_incremental_pid_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pipid_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pipid_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pipid_pkg::DATA_W-1:0] err_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pipid_pkg::DATA_W-1:0] drive_o,
  output logic                                saturated_o
);

  pipid_pkg::cfg_t  cfg;
  pipid_pkg::opnd_t ops;
  pipid_pkg::prod_t prod;
  logic             ops_valid;
  logic             ops_ready;
  logic             prod_valid;
  logic             prod_ready;

  pipid_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pipid_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .err_sample_i (err_sample_i),
    .ops_valid_o  (ops_valid),
    .ops_ready_i  (ops_ready),
    .ops_o        (ops)
  );

  pipid_mul u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .ops_valid_i  (ops_valid),
    .ops_ready_o  (ops_ready),
    .ops_i        (ops),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod)
  );

  pipid_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_o      (drive_o),
    .saturated_o  (saturated_o)
  );

endmodule

// ===== rtl/core/pipid_cfg.sv =====
// ----------------------------------------------------------------------------
// pipid_cfg
// Configuration register file: mode, three gains and the integrator limit.
// ----------------------------------------------------------------------------
module pipid_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pipid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pipid_pkg::DATA_W-1:0]         cfg_data_i,
  output pipid_pkg::cfg_t                      cfg_o
);

  pipid_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (pipid_pkg::cfg_idx_e'(cfg_index_i))
        pipid_pkg::CFG_MODE:        cfg_q.mode_incremental <= cfg_data_i[0];
        pipid_pkg::CFG_GAIN_P:      cfg_q.gain_p           <= cfg_data_i;
        pipid_pkg::CFG_GAIN_I:      cfg_q.gain_i           <= cfg_data_i;
        pipid_pkg::CFG_GAIN_D:      cfg_q.gain_d           <= cfg_data_i;
        pipid_pkg::CFG_INTEG_LIMIT: cfg_q.integ_limit      <= cfg_data_i[pipid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/pipid_front.sv =====
// ----------------------------------------------------------------------------
// pipid_front
// Error differences, clamped integrator and multiplier operand selection.
// ----------------------------------------------------------------------------
module pipid_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pipid_pkg::cfg_t                     cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pipid_pkg::DATA_W-1:0] err_sample_i,
  output logic                                ops_valid_o,
  input  logic                                ops_ready_i,
  output pipid_pkg::opnd_t                    ops_o
);

  localparam int unsigned W = pipid_pkg::DATA_W;

  logic                 valid_q;
  logic                 fire;
  logic signed [W-1:0]  prev_err_q;
  logic signed [W-1:0]  integ_q;
  logic signed [W-1:0]  prev_delta_q;
  logic signed [W:0]    d_full;
  logic signed [W:0]    ig_full;
  logic signed [W:0]    dd_full;
  logic signed [W-1:0]  d;
  logic signed [W-1:0]  ig_sat;
  logic signed [W-1:0]  ig;
  logic signed [W-1:0]  dd;
  logic signed [W-1:0]  lim;
  logic signed [W-1:0]  lim_neg;
  pipid_pkg::opnd_t     ops_d;
  pipid_pkg::opnd_t     ops_q;

  assign in_ready_o  = !valid_q || ops_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign ops_valid_o = valid_q;
  assign ops_o       = ops_q;

  always_comb begin
    d_full  = (W+1)'(err_sample_i) - (W+1)'(prev_err_q);
    d       = pipid_pkg::sat33(d_full);
    ig_full = (W+1)'(integ_q) + (W+1)'(err_sample_i);
    ig_sat  = pipid_pkg::sat33(ig_full);
    lim     = $signed({1'b0, cfg_i.integ_limit});
    lim_neg = -lim;
    ig      = ig_sat;
    if (ig_sat > lim) begin
      ig = lim;
    end
    if (ig_sat < lim_neg) begin
      ig = lim_neg;
    end
    dd_full = (W+1)'(d) - (W+1)'(prev_delta_q);
    dd      = pipid_pkg::sat33(dd_full);

    ops_d.opnd_p = err_sample_i;
    if (cfg_i.mode_incremental) begin
      ops_d.opnd_i = d;
      ops_d.opnd_d = dd;
      ops_d.flag   = pipid_pkg::ovf33(d_full) | pipid_pkg::ovf33(dd_full);
    end else begin
      ops_d.opnd_i = ig;
      ops_d.opnd_d = d;
      ops_d.flag   = pipid_pkg::ovf33(d_full) | pipid_pkg::ovf33(ig_full);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      prev_err_q   <= '0;
      integ_q      <= '0;
      prev_delta_q <= '0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (fire) begin
        prev_err_q <= err_sample_i;
        if (cfg_i.mode_incremental) begin
          prev_delta_q <= d;
        end else begin
          integ_q <= ig;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ops_q <= ops_d;
    end
  end

  // After each request taken in positional mode the integrator is within the configured band.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !cfg_i.mode_incremental |=>
      (integ_q <= $signed({1'b0, $past(cfg_i.integ_limit)})) &&
      (integ_q >= -$signed({1'b0, $past(cfg_i.integ_limit)})))
    else $error("integrator outside its limit");

  // Controller state moves only when a request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(prev_err_q) && $stable(integ_q) && $stable(prev_delta_q))
    else $error("controller state changed without a request");

endmodule

// ===== rtl/core/pipid_mul.sv =====
// ----------------------------------------------------------------------------
// pipid_mul
// Three parallel signed gain products, registered at full width.
// ----------------------------------------------------------------------------
module pipid_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pipid_pkg::cfg_t  cfg_i,
  input  logic             ops_valid_i,
  output logic             ops_ready_o,
  input  pipid_pkg::opnd_t ops_i,
  output logic             prod_valid_o,
  input  logic             prod_ready_i,
  output pipid_pkg::prod_t prod_o
);

  logic             valid_q;
  logic             fire;
  pipid_pkg::prod_t prod_d;
  pipid_pkg::prod_t prod_q;

  assign ops_ready_o  = !valid_q || prod_ready_i;
  assign fire         = ops_valid_i && ops_ready_o;
  assign prod_valid_o = valid_q;
  assign prod_o       = prod_q;

  always_comb begin
    prod_d.prod_p = $signed(cfg_i.gain_p) * $signed(ops_i.opnd_p);
    prod_d.prod_i = $signed(cfg_i.gain_i) * $signed(ops_i.opnd_i);
    prod_d.prod_d = $signed(cfg_i.gain_d) * $signed(ops_i.opnd_d);
    prod_d.flag   = ops_i.flag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ops_ready_o) begin
      valid_q <= ops_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      prod_q <= prod_d;
    end
  end

endmodule

// ===== rtl/core/pipid_back.sv =====
// ----------------------------------------------------------------------------
// pipid_back
// Product scaling, saturating output sum and the output register.
// ----------------------------------------------------------------------------
module pipid_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pipid_pkg::cfg_t                      cfg_i,
  input  logic                                 prod_valid_i,
  output logic                                 prod_ready_o,
  input  pipid_pkg::prod_t                     prod_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pipid_pkg::DATA_W-1:0]  drive_o,
  output logic                                 saturated_o
);

  localparam int unsigned W  = pipid_pkg::DATA_W;
  localparam int unsigned SW = W + 2;

  logic                  valid_q;
  logic                  fire;
  logic signed [W-1:0]   drive_q;
  logic                  sat_q;
  logic signed [2*W-1:0] q_p;
  logic signed [2*W-1:0] q_i;
  logic signed [2*W-1:0] q_d;
  logic signed [W-1:0]   t_p;
  logic signed [W-1:0]   t_i;
  logic signed [W-1:0]   t_d;
  logic signed [W-1:0]   acc;
  logic signed [SW-1:0]  total;
  logic signed [W-1:0]   drive_d;
  logic                  sat_d;

  assign prod_ready_o = !valid_q || out_ready_i;
  assign fire         = prod_valid_i && prod_ready_o;
  assign out_valid_o  = valid_q;
  assign drive_o      = drive_q;
  assign saturated_o  = sat_q;

  always_comb begin
    q_p   = pipid_pkg::qscale(prod_i.prod_p);
    q_i   = pipid_pkg::qscale(prod_i.prod_i);
    q_d   = pipid_pkg::qscale(prod_i.prod_d);
    t_p   = pipid_pkg::sat64(q_p);
    t_i   = pipid_pkg::sat64(q_i);
    t_d   = pipid_pkg::sat64(q_d);
    acc   = cfg_i.mode_incremental ? drive_q : '0;
    total = SW'(acc) + SW'(t_p) + SW'(t_i) + SW'(t_d);
    sat_d = prod_i.flag | pipid_pkg::ovf64(q_p) | pipid_pkg::ovf64(q_i) |
            pipid_pkg::ovf64(q_d);
    if (total > SW'(pipid_pkg::S32_MAX)) begin
      drive_d = pipid_pkg::S32_MAX;
      sat_d   = 1'b1;
    end else if (total < SW'(pipid_pkg::S32_MIN)) begin
      drive_d = pipid_pkg::S32_MIN;
      sat_d   = 1'b1;
    end else begin
      drive_d = total[W-1:0];
    end
  end

  // In incremental mode the drive register doubles as the running output accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      drive_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      if (prod_ready_o) begin
        valid_q <= prod_valid_i;
      end
      if (fire) begin
        drive_q <= drive_d;
        sat_q   <= sat_d;
      end
    end
  end

  // A delivered result with nothing behind it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_ready_i && !prod_valid_i |=> !valid_q)
    else $error("output stayed valid after delivery");

  // The accumulator changes only when a new result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(drive_q) && $stable(sat_q))
    else $error("output changed without a new result");

endmodule
